[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds, in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The condition must never hold.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

[rtl/core/upq_pkg.sv]
// ----------------------------------------------------------------------------
// Priority queue package
// Types and codes shared by the queue core and its stream interfaces.
// ----------------------------------------------------------------------------
package upq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      STAT_ENQUEUED = 2'd0,
      STAT_DEQUEUED = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] entry_priority;
      logic [31:0]        entry_tag;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] out_priority;
      logic [31:0]        out_tag;
   } rsp_word_type;

endpackage

[rtl/core/upq_stream_if.sv]
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel that moves one word of a given payload type.
// ----------------------------------------------------------------------------
interface upq_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/unsorted_max_priority_queue.sv]
// ----------------------------------------------------------------------------
// Unsorted max-priority queue
// Bounded queue of priority/tag entries kept in arrival order in two memories.
// ----------------------------------------------------------------------------
// An enqueue word appends one entry and returns its status in the cycle after
// acceptance; an enqueue on a full queue is refused with status full. A
// dequeue word scans the stored entries newest to oldest with one comparator,
// one entry per cycle, returns the highest priority (the newest one among
// ties), then closes the gap by moving each later entry down one slot, one
// entry per cycle through the one write port. A dequeue on an empty queue
// returns status empty without a scan or shift. The input is not ready while
// a dequeue is in progress.
module unsorted_max_priority_queue #(
   parameter int DEPTH = upq_pkg::DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   upq_stream_if.sink     req_if,
   upq_stream_if.source   rsp_if
);
   import upq_pkg::*;

`include "assert_macros.svh"

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [15:0] slot_priority_mem [DEPTH];
   logic [31:0]        slot_tag_mem [DEPTH];

   state_type          state_ff, state_in;
   logic [CW-1:0]      occ_ff, occ_in;
   logic [AW-1:0]      scan_idx_ff, scan_idx_in;
   logic [AW-1:0]      wr_idx_ff, wr_idx_in;
   logic               first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic signed [15:0] best_prio_ff, best_prio_in;
   logic [31:0]        best_tag_ff, best_tag_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic signed [15:0] rd_prio_ff;
   logic [31:0]        rd_tag_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [15:0] wr_prio;
   logic [31:0]        wr_tag;
   logic [AW-1:0]      rd_addr;
   logic               req_ready;
   logic               out_free;
   logic               take;
   logic [CW-1:0]      occ_last;
   logic [AW-1:0]      cand_idx;
   req_word_type       req_word;

   assign req_word       = req_if.payload;
   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_word_ff;
   assign out_free       = !rsp_valid_ff || rsp_if.ready;
   assign occ_last       = occ_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_priority_mem[wr_addr] <= wr_prio;
         slot_tag_mem[wr_addr]      <= wr_tag;
      end
      rd_prio_ff <= slot_priority_mem[rd_addr];
      rd_tag_ff  <= slot_tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      wr_idx_ff    <= wr_idx_in;
      first_ff     <= first_in;
      rsp_word_ff  <= rsp_word_in;
      best_prio_ff <= best_prio_in;
      best_tag_ff  <= best_tag_in;
      best_idx_ff  <= best_idx_in;
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      scan_idx_in  = scan_idx_ff;
      wr_idx_in    = wr_idx_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_word_in  = rsp_word_ff;
      best_prio_in = best_prio_ff;
      best_tag_in  = best_tag_ff;
      best_idx_in  = best_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = wr_idx_ff;
      wr_prio      = rd_prio_ff;
      wr_tag       = rd_tag_ff;
      rd_addr      = '0;
      req_ready    = 1'b0;
      take         = first_ff || (rd_prio_ff > best_prio_ff);
      cand_idx     = take ? scan_idx_ff : best_idx_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = out_free;
            if (req_if.valid && out_free) begin
               if (req_word.mode == MODE_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '{status: STAT_FULL, out_priority: '0, out_tag: '0};
                  if (occ_ff != CW'(DEPTH)) begin
                     wr_en       = 1'b1;
                     wr_addr     = occ_ff[AW-1:0];
                     wr_prio     = req_word.entry_priority;
                     wr_tag      = req_word.entry_tag;
                     occ_in      = occ_ff + CW'(1);
                     rsp_word_in.status = STAT_ENQUEUED;
                  end
               end else if (occ_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '{status: STAT_EMPTY, out_priority: '0, out_tag: '0};
               end else begin
                  rd_addr     = occ_last[AW-1:0];
                  scan_idx_in = occ_last[AW-1:0];
                  first_in    = 1'b1;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            first_in = 1'b0;
            if (take) begin
               best_prio_in = rd_prio_ff;
               best_tag_in  = rd_tag_ff;
               best_idx_in  = scan_idx_ff;
            end
            if (scan_idx_ff != '0) begin
               rd_addr     = scan_idx_ff - AW'(1);
               scan_idx_in = scan_idx_ff - AW'(1);
            end else begin
               rd_addr   = cand_idx + AW'(1);
               wr_idx_in = cand_idx;
               state_in  = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if ((CW'(wr_idx_ff) + CW'(1)) < occ_ff) begin
               wr_en     = 1'b1;
               rd_addr   = wr_idx_ff + AW'(2);
               wr_idx_in = wr_idx_ff + AW'(1);
            end else begin
               occ_in   = occ_last;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{status: STAT_DEQUEUED, out_priority: best_prio_ff,
                                out_tag: best_tag_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `ASSERT_NEVER(a_occ_bound, occ_ff > CW'(DEPTH), "occupancy above depth")
   `ASSERT_NEXT(a_empty_deq,
      req_if.valid && req_ready && req_word.mode == MODE_DEQUEUE && occ_ff == '0,
      rsp_valid_ff && rsp_word_ff.status == STAT_EMPTY && occ_ff == '0,
      "empty dequeue mishandled")
   `ASSERT_NEXT(a_full_enq,
      req_if.valid && req_ready && req_word.mode == MODE_ENQUEUE && occ_ff == CW'(DEPTH),
      rsp_word_ff.status == STAT_FULL && occ_ff == $past(occ_ff),
      "full enqueue changed state")
   `ASSERT_IMPLIES(a_busy_hold, state_ff == S_SCAN || state_ff == S_SHIFT, occ_ff != '0,
      "dequeue in progress on empty queue")

endmodule
